### src/lbph_pkg.sv
// Shared constants, code names and lookup functions for the spectrum bar history.
// Used by log_band_peak_bar_history; no dependencies.
`timescale 1ns / 1ps

package lbph_pkg;

  // Item operation codes
  localparam logic OP_SAMPLE  = 1'b0;
  localparam logic OP_REFRESH = 1'b1;

  // Configuration register indexes
  localparam logic [0:0] REG_GAIN_SELECT = 1'b0;
  localparam logic [0:0] REG_SLEW_SELECT = 1'b1;

  localparam int SELECT_BITS = 3;
  localparam logic [SELECT_BITS-1:0] SELECT_MAX = 3'd4;

  // Gain select codes
  localparam logic [SELECT_BITS-1:0] GAIN_X1_00 = 3'd0;
  localparam logic [SELECT_BITS-1:0] GAIN_X2_00 = 3'd1;
  localparam logic [SELECT_BITS-1:0] GAIN_X3_00 = 3'd2;
  localparam logic [SELECT_BITS-1:0] GAIN_X0_50 = 3'd3;
  localparam logic [SELECT_BITS-1:0] GAIN_X0_33 = 3'd4;

  // Slew select codes
  localparam logic [SELECT_BITS-1:0] SLEW_0_0500 = 3'd0;
  localparam logic [SELECT_BITS-1:0] SLEW_0_0250 = 3'd1;
  localparam logic [SELECT_BITS-1:0] SLEW_0_0125 = 3'd2;
  localparam logic [SELECT_BITS-1:0] SLEW_0_1000 = 3'd3;
  localparam logic [SELECT_BITS-1:0] SLEW_0_2000 = 3'd4;

  // Band boundaries over sample positions
  localparam int TABLE_BANDS    = 16;
  localparam int BAND_IDX_BITS  = 4;
  localparam int EDGE_IDX_BITS  = 5;
  localparam int POS_BITS       = 8;
  localparam logic [POS_BITS-1:0] POS_LAST = 8'd255;
  localparam logic [POS_BITS-1:0] BAND_EDGE [TABLE_BANDS+1] = '{
    8'd0, 8'd1, 8'd2, 8'd3, 8'd5, 8'd7, 8'd10, 8'd14, 8'd20,
    8'd28, 8'd40, 8'd54, 8'd74, 8'd101, 8'd137, 8'd187, 8'd255};

  // Sample and peak widths
  localparam int SAMPLE_BITS = 16;
  localparam int RUN_BITS    = 15;
  localparam int PEAK_BITS   = 8;
  localparam int PEAK_SHIFT  = 7;

  // Bit-serial log2: Q3.24 result, mantissa held in Q1.30
  localparam int LOG_STEPS    = 24;
  localparam int ITER_BITS    = 5;
  localparam int EXP_BITS     = 3;
  localparam int MANT_BITS    = 31;
  localparam int SQUARE_BITS  = 2 * MANT_BITS;
  localparam int LOG_BITS     = EXP_BITS + LOG_STEPS;

  // Gain in Q.16 and product width
  localparam int GAIN_BITS = 18;
  localparam int PROD_BITS = LOG_BITS + GAIN_BITS;

  // Slew step in Q.24
  localparam int SLEW_BITS = 24;

  function automatic logic [GAIN_BITS-1:0] gain_q16(input logic [SELECT_BITS-1:0] sel);
    logic [GAIN_BITS-1:0] g;
    unique case (sel)
      GAIN_X1_00: g = 18'd65536;
      GAIN_X2_00: g = 18'd131072;
      GAIN_X3_00: g = 18'd196608;
      GAIN_X0_50: g = 18'd32768;
      GAIN_X0_33: g = 18'd21627;
      default:    g = '0;
    endcase
    return g;
  endfunction

  function automatic logic [SLEW_BITS-1:0] slew_q24(input logic [SELECT_BITS-1:0] sel);
    logic [SLEW_BITS-1:0] s;
    unique case (sel)
      SLEW_0_0500: s = 24'd838861;
      SLEW_0_0250: s = 24'd419430;
      SLEW_0_0125: s = 24'd209715;
      SLEW_0_1000: s = 24'd1677722;
      SLEW_0_2000: s = 24'd3355443;
      default:     s = '0;
    endcase
    return s;
  endfunction

endpackage

### src/lbph_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lbph_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### src/log_band_peak_bar_history.sv
// Spectrum bar history: band peak tracking, log height commit and slewed display cells.
// Depends on lbph_pkg and lbph_ram.
`timescale 1ns / 1ps

// Audio items (operation 0) are taken back to back while the block is idle. A
// refresh item (operation 1) reads the history and display RAMs at the transfer;
// the slewed height is then written back and registered for output in the
// resolve state, which waits while a previous result is still held on the
// output, and no new item is taken before it is done.
// The last sample of a frame starts a commit that walks the bands one at a
// time: a band with a zero peak is only loaded and written, any other band is
// loaded, run through 24 iterations of the squaring log unit, gain multiplied,
// rounded and written; no item is taken before the whole commit is done.
// After reset both RAMs are swept to zero, one entry a cycle, over their whole
// depth; items are held off during the sweep, configuration writes are not.
// Heights are unsigned with HEIGHT_BITS-2 fraction bits.
module log_band_peak_bar_history #(
  parameter int BAND_COUNT   = 16,
  parameter int HISTORY_ROWS = 16,
  parameter int HEIGHT_BITS  = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration
  input  logic                   cfg_write,
  input  logic [0:0]             cfg_index,
  input  logic [2:0]             cfg_data,
  // input channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   operation,
  input  logic signed [15:0]     sample_value,
  input  logic                   frame_last,
  input  logic [3:0]             cell_row,
  input  logic [3:0]             cell_column,
  // output channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [3:0]             out_row,
  output logic [3:0]             out_column,
  output logic [HEIGHT_BITS-1:0] shown_height,
  output logic [HEIGHT_BITS-1:0] target_height
);

  localparam int HF    = HEIGHT_BITS - 2;
  localparam int RW    = (HISTORY_ROWS > 1) ? $clog2(HISTORY_ROWS) : 1;
  localparam int CW    = $clog2(BAND_COUNT);
  localparam int AW    = RW + CW;
  localparam int DEPTH = 1 << AW;
  localparam int LIMIT = (BAND_COUNT < lbph_pkg::TABLE_BANDS) ?
                         BAND_COUNT : lbph_pkg::TABLE_BANDS;
  localparam int SUMW  = lbph_pkg::PROD_BITS + 1;
  localparam int RSH   = 43 - HF;
  localparam int SSH   = 24 - HF;
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_MAX = HEIGHT_BITS'(3) << HF;

  typedef enum logic [6:0] {
    ST_CLEAR   = 7'b0000001,
    ST_IDLE    = 7'b0000010,
    ST_RESOLVE = 7'b0000100,
    ST_LOAD    = 7'b0001000,
    ST_LOG     = 7'b0010000,
    ST_SCALE   = 7'b0100000,
    ST_WRITE   = 7'b1000000
  } state_t;

  state_t state;

  // control state
  logic [lbph_pkg::SELECT_BITS-1:0] gain_select;
  logic [lbph_pkg::SELECT_BITS-1:0] slew_select;
  logic [RW-1:0]                    newest_row_pointer;
  logic [lbph_pkg::RUN_BITS-1:0]    running_peak;
  logic [lbph_pkg::POS_BITS-1:0]    sample_position;
  logic [lbph_pkg::PEAK_BITS-1:0]   band_peaks [BAND_COUNT];
  logic [AW-1:0]                    clear_addr;
  logic [CW-1:0]                    commit_band;
  logic [lbph_pkg::ITER_BITS-1:0]   log_iter;

  // datapath registers
  logic [lbph_pkg::EXP_BITS-1:0]    log_exp;
  logic [lbph_pkg::LOG_STEPS-1:0]   log_frac;
  logic [lbph_pkg::MANT_BITS-1:0]   mant;
  logic [lbph_pkg::PROD_BITS-1:0]   prod;
  logic [AW-1:0]                    shown_addr;
  logic [3:0]                       pend_row;
  logic [3:0]                       pend_column;

  // RAM ports
  logic                   hist_wr_en;
  logic [AW-1:0]          hist_wr_addr;
  logic [HEIGHT_BITS-1:0] hist_wr_data;
  logic [AW-1:0]          hist_rd_addr;
  logic [HEIGHT_BITS-1:0] hist_rd_data;
  logic                   shown_wr_en;
  logic [AW-1:0]          shown_wr_addr;
  logic [HEIGHT_BITS-1:0] shown_wr_data;
  logic [AW-1:0]          shown_rd_addr;
  logic [HEIGHT_BITS-1:0] shown_rd_data;

  // combinational
  logic                               take;
  logic                               take_sample;
  logic                               take_refresh;
  logic                               out_free;
  logic [RW-1:0]                      row_mod [16];
  logic [CW-1:0]                      col_mod [16];
  logic [RW:0]                        phys_sum;
  logic [RW-1:0]                      phys_row;
  logic [lbph_pkg::BAND_IDX_BITS-1:0] tab_band;
  logic                               band_ok;
  logic [lbph_pkg::POS_BITS-1:0]      next_edge;
  logic                               band_close;
  logic [lbph_pkg::RUN_BITS-1:0]      peak_upd;
  logic [lbph_pkg::PEAK_BITS-1:0]     load_peak;
  logic [lbph_pkg::EXP_BITS-1:0]      load_exp;
  logic [lbph_pkg::SQUARE_BITS-1:0]   square;
  logic [lbph_pkg::MANT_BITS:0]       square_top;
  logic [SUMW-1:0]                    rounded;
  logic [HEIGHT_BITS-1:0]             height;
  logic [lbph_pkg::SLEW_BITS-1:0]     step_wide;
  logic [HEIGHT_BITS-1:0]             step;
  logic [HEIGHT_BITS-1:0]             shown_new;

  assign take         = in_valid && !in_stall;
  assign take_sample  = take && (operation == lbph_pkg::OP_SAMPLE);
  assign take_refresh = take && (operation == lbph_pkg::OP_REFRESH);
  assign in_stall     = (state != ST_IDLE);
  assign out_free     = !out_valid || !out_stall;

  // Row and column reduction tables for out-of-range cells
  for (genvar gi = 0; gi < 16; gi++) begin : g_mod
    assign row_mod[gi] = RW'(gi % HISTORY_ROWS);
    assign col_mod[gi] = CW'(gi % BAND_COUNT);
  end

  // Physical history row of the refreshed cell
  always_comb begin
    phys_sum = {1'b0, newest_row_pointer} + {1'b0, row_mod[cell_row]};
    if (phys_sum >= (RW+1)'(HISTORY_ROWS)) begin
      phys_sum = phys_sum - (RW+1)'(HISTORY_ROWS);
    end
    phys_row      = phys_sum[RW-1:0];
    hist_rd_addr  = {phys_row, col_mod[cell_column]};
    shown_rd_addr = {row_mod[cell_row], col_mod[cell_column]};
  end

  // Band lookup and running peak for an incoming sample
  always_comb begin
    tab_band = '0;
    for (int k = 1; k < lbph_pkg::TABLE_BANDS; k++) begin
      if (lbph_pkg::BAND_EDGE[k] <= sample_position) begin
        tab_band = lbph_pkg::BAND_IDX_BITS'(k);
      end
    end
    band_ok = (sample_position != lbph_pkg::POS_LAST) &&
              ({1'b0, tab_band} < (lbph_pkg::BAND_IDX_BITS+1)'(LIMIT));
    next_edge  = lbph_pkg::BAND_EDGE[{1'b0, tab_band} + lbph_pkg::EDGE_IDX_BITS'(1)];
    band_close = frame_last || (sample_position + 8'd1 == next_edge);
    peak_upd   = running_peak;
    if (!sample_value[15] && (sample_value[14:0] > running_peak)) begin
      peak_upd = sample_value[14:0];
    end
  end

  // Normalization of the band peak for the log unit
  always_comb begin
    load_peak = band_peaks[commit_band];
    load_exp  = '0;
    for (int i = 1; i < lbph_pkg::PEAK_BITS; i++) begin
      if (load_peak[i]) begin
        load_exp = lbph_pkg::EXP_BITS'(i);
      end
    end
  end

  // One squaring step of the log unit
  always_comb begin
    square     = lbph_pkg::SQUARE_BITS'(mant) * lbph_pkg::SQUARE_BITS'(mant);
    square_top = square[lbph_pkg::SQUARE_BITS-1:lbph_pkg::MANT_BITS-1];
  end

  // Rounding and saturation of the scaled log
  always_comb begin
    rounded = ({1'b0, prod} + (SUMW'(1) << (RSH - 1))) >> RSH;
    if (rounded > SUMW'(HEIGHT_MAX)) begin
      height = HEIGHT_MAX;
    end else begin
      height = HEIGHT_BITS'(rounded);
    end
  end

  // Slew of the displayed height toward the history height
  always_comb begin
    step_wide = (lbph_pkg::slew_q24(slew_select) +
                 (lbph_pkg::SLEW_BITS'(1) << (SSH - 1))) >> SSH;
    step      = HEIGHT_BITS'(step_wide);
    shown_new = shown_rd_data;
    if ((shown_rd_data < hist_rd_data) && (hist_rd_data - shown_rd_data > step)) begin
      shown_new = shown_rd_data + step;
    end else if ((shown_rd_data > hist_rd_data) &&
                 (shown_rd_data - hist_rd_data > step)) begin
      shown_new = shown_rd_data - step;
    end
  end

  // RAM write selection
  always_comb begin
    hist_wr_en    = (state == ST_CLEAR) || (state == ST_WRITE);
    hist_wr_addr  = (state == ST_CLEAR) ? clear_addr : {newest_row_pointer, commit_band};
    hist_wr_data  = (state == ST_CLEAR) ? '0 : height;
    shown_wr_en   = (state == ST_CLEAR) || ((state == ST_RESOLVE) && out_free);
    shown_wr_addr = (state == ST_CLEAR) ? clear_addr : shown_addr;
    shown_wr_data = (state == ST_CLEAR) ? '0 : shown_new;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_select <= '0;
      slew_select <= '0;
    end else if (cfg_write && (cfg_data <= lbph_pkg::SELECT_MAX)) begin
      unique case (cfg_index)
        lbph_pkg::REG_GAIN_SELECT: gain_select <= cfg_data;
        lbph_pkg::REG_SLEW_SELECT: slew_select <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer, peak tracking and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_CLEAR;
      newest_row_pointer <= '0;
      running_peak       <= '0;
      sample_position    <= '0;
      clear_addr         <= '0;
      commit_band        <= '0;
      log_iter           <= '0;
      out_valid          <= 1'b0;
      for (int b = 0; b < BAND_COUNT; b++) begin
        band_peaks[b] <= '0;
      end
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clear_addr <= clear_addr + AW'(1);
          if (clear_addr == AW'(DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (take_refresh) begin
            state <= ST_RESOLVE;
          end else if (take_sample) begin
            if (band_ok) begin
              running_peak <= band_close ? '0 : peak_upd;
              if (band_close) begin
                band_peaks[CW'(tab_band)] <=
                  peak_upd[lbph_pkg::RUN_BITS-1:lbph_pkg::PEAK_SHIFT];
              end
            end
            if (sample_position != lbph_pkg::POS_LAST) begin
              sample_position <= sample_position + 8'd1;
            end
            if (frame_last) begin
              newest_row_pointer <= (newest_row_pointer == '0) ?
                                    RW'(HISTORY_ROWS - 1) : newest_row_pointer - RW'(1);
              running_peak       <= '0;
              sample_position    <= '0;
              commit_band        <= '0;
              state              <= ST_LOAD;
            end
          end
        end
        ST_RESOLVE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        ST_LOAD: begin
          band_peaks[commit_band] <= '0;
          log_iter <= '0;
          state    <= (load_peak == '0) ? ST_WRITE : ST_LOG;
        end
        ST_LOG: begin
          log_iter <= log_iter + lbph_pkg::ITER_BITS'(1);
          if (log_iter == lbph_pkg::ITER_BITS'(lbph_pkg::LOG_STEPS - 1)) begin
            state <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          state <= ST_WRITE;
        end
        ST_WRITE: begin
          commit_band <= commit_band + CW'(1);
          if (commit_band == CW'(BAND_COUNT - 1)) begin
            state <= ST_IDLE;
          end else begin
            state <= ST_LOAD;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Log unit, gain product and pending refresh cell
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (take_refresh) begin
          shown_addr  <= shown_rd_addr;
          pend_row    <= cell_row;
          pend_column <= cell_column;
        end
      end
      ST_LOAD: begin
        log_exp  <= load_exp;
        log_frac <= '0;
        mant     <= lbph_pkg::MANT_BITS'(load_peak) <<
                    (lbph_pkg::MANT_BITS - 1 - int'(load_exp));
        prod     <= '0;
      end
      ST_LOG: begin
        if (square_top[lbph_pkg::MANT_BITS]) begin
          mant     <= square_top[lbph_pkg::MANT_BITS:1];
          log_frac <= {log_frac[lbph_pkg::LOG_STEPS-2:0], 1'b1};
        end else begin
          mant     <= square_top[lbph_pkg::MANT_BITS-1:0];
          log_frac <= {log_frac[lbph_pkg::LOG_STEPS-2:0], 1'b0};
        end
      end
      ST_SCALE: begin
        prod <= lbph_pkg::PROD_BITS'({log_exp, log_frac}) *
                lbph_pkg::PROD_BITS'(lbph_pkg::gain_q16(gain_select));
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if ((state == ST_RESOLVE) && out_free) begin
      out_row       <= pend_row;
      out_column    <= pend_column;
      shown_height  <= shown_new;
      target_height <= hist_rd_data;
    end
  end

  lbph_ram #(
    .WIDTH (HEIGHT_BITS),
    .DEPTH (DEPTH)
  ) u_history_ram (
    .clk     (clk),
    .wr_en   (hist_wr_en),
    .wr_addr (hist_wr_addr),
    .wr_data (hist_wr_data),
    .rd_en   (take_refresh),
    .rd_addr (hist_rd_addr),
    .rd_data (hist_rd_data)
  );

  lbph_ram #(
    .WIDTH (HEIGHT_BITS),
    .DEPTH (DEPTH)
  ) u_shown_ram (
    .clk     (clk),
    .wr_en   (shown_wr_en),
    .wr_addr (shown_wr_addr),
    .wr_data (shown_wr_data),
    .rd_en   (take_refresh),
    .rd_addr (shown_rd_addr),
    .rd_data (shown_rd_data)
  );

endmodule
